@@ hdl/tsc_pkg.sv @@
// Shared types and constants for the touch sensor conditioner.
package tsc_pkg;

  // Ring depth and field widths.
  localparam int unsigned WINDOW  = 5;
  localparam int unsigned IDX_W   = $clog2(WINDOW);
  localparam int unsigned VOLT_W  = 10;
  localparam int unsigned CAP_W   = 24;
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Accumulator width: WINDOW signed capacitance values never overflow it.
  localparam int unsigned SUM_W = CAP_W + $clog2(WINDOW);

  // Reciprocal of WINDOW scaled by 2^SUM_W, rounded down.
  localparam int unsigned DIV_RECIP = (32'd1 << SUM_W) / WINDOW;

  // Register reset values.
  localparam logic signed [CAP_W-1:0] TH_HIGH_RST = 24'sd100;
  localparam logic signed [CAP_W-1:0] TH_LOW_RST  = 24'sd50;

  // Event codes carried in the op field.
  typedef enum logic [OP_W-1:0] {
    OP_VOLT   = 2'd0,
    OP_CAP    = 2'd1,
    OP_DECIDE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWITCH_TYPE = 2'd0,
    CFG_TH_HIGH     = 2'd1,
    CFG_TH_LOW      = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  // Which ring the shared adder is walking through.
  typedef enum logic [1:0] {
    PASS_RAW,
    PASS_MEAN,
    PASS_CAP
  } pass_e;

  // Input and result items.
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [VOLT_W-1:0]       volt_sample;
    logic signed [CAP_W-1:0] cap_sample;
  } in_t;

  typedef struct packed {
    logic [VOLT_W-1:0]       smoothed_volt;
    logic signed [CAP_W-1:0] smoothed_cap;
    logic                    touched;
  } out_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    pass_e            pass;
    logic [IDX_W-1:0] idx;
    logic             accept;
    logic             acc_add;
    logic             div_go;
    logic             div_take;
  } ctl_t;

endpackage

@@ hdl/tsc_cdiv.sv @@
// Signed division of a ring sum by WINDOW, truncating toward zero.
// Two stages: a reciprocal multiply, then a single remainder correction.
module tsc_cdiv (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 go_i,
  input  logic signed [tsc_pkg::SUM_W-1:0]     sum_i,
  output logic                                 done_o,
  output logic signed [tsc_pkg::SUM_W-1:0]     quot_o
);

  logic [tsc_pkg::SUM_W-1:0]   mag;
  logic [2*tsc_pkg::SUM_W-1:0] prod;
  logic [tsc_pkg::SUM_W-1:0]   mag_q, q_est_q, q_times_w, rem, q_fix;
  logic                        neg_q;
  logic signed [tsc_pkg::SUM_W-1:0] quot_d, quot_q;
  logic [1:0]                  vld_q;

  // Stage one: magnitude times the scaled reciprocal; the estimate is low by at most one.
  always_comb begin
    mag  = sum_i[tsc_pkg::SUM_W-1] ? tsc_pkg::SUM_W'(-sum_i) : tsc_pkg::SUM_W'(sum_i);
    prod = (2*tsc_pkg::SUM_W)'(mag) *
           (2*tsc_pkg::SUM_W)'(tsc_pkg::SUM_W'(tsc_pkg::DIV_RECIP));
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      mag_q   <= mag;
      q_est_q <= prod[2*tsc_pkg::SUM_W-1:tsc_pkg::SUM_W];
      neg_q   <= sum_i[tsc_pkg::SUM_W-1];
    end
  end

  // Stage two: bump the estimate when the remainder reaches the divisor, then restore the sign.
  always_comb begin
    q_times_w = tsc_pkg::SUM_W'(q_est_q * tsc_pkg::SUM_W'(tsc_pkg::WINDOW));
    rem       = mag_q - q_times_w;
    q_fix     = (rem >= tsc_pkg::SUM_W'(tsc_pkg::WINDOW)) ? q_est_q + 1'b1 : q_est_q;
    quot_d    = neg_q ? -$signed(q_fix) : $signed(q_fix);
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      quot_q <= quot_d;
    end
  end

  // Valid pipe that tracks the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 2'b00;
    end else begin
      vld_q <= {vld_q[0], go_i};
    end
  end

  assign done_o = vld_q[1];
  assign quot_o = quot_q;

endmodule

@@ hdl/tsc_ctrl.sv @@
// Sequencer: walks the shared adder over one ring at a time and drives the divider.
module tsc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [tsc_pkg::OP_W-1:0] in_op_i,
  input  logic                     out_ready_i,
  input  logic                     div_done_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  output tsc_pkg::ctl_t            ctl_o
);

  tsc_pkg::state_e            state_d, state_q;
  tsc_pkg::pass_e             pass_d, pass_q;
  logic [tsc_pkg::IDX_W-1:0]  cnt_d, cnt_q;
  logic                       accept;

  assign accept = in_valid_i && (state_q == tsc_pkg::ST_IDLE);

  // Next state, pass and ring index.
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cnt_d   = cnt_q;
    case (state_q)
      tsc_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          if (in_op_i == tsc_pkg::OP_VOLT) begin
            pass_d  = tsc_pkg::PASS_RAW;
            state_d = tsc_pkg::ST_SUM;
          end else if (in_op_i == tsc_pkg::OP_CAP) begin
            pass_d  = tsc_pkg::PASS_CAP;
            state_d = tsc_pkg::ST_SUM;
          end else begin
            state_d = tsc_pkg::ST_OUT;
          end
        end
      end
      tsc_pkg::ST_SUM: begin
        if (cnt_q == tsc_pkg::IDX_W'(tsc_pkg::WINDOW - 1)) begin
          state_d = tsc_pkg::ST_DIV_GO;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tsc_pkg::ST_DIV_GO: begin
        state_d = tsc_pkg::ST_DIV_WAIT;
      end
      tsc_pkg::ST_DIV_WAIT: begin
        if (div_done_i) begin
          if (pass_q == tsc_pkg::PASS_RAW) begin
            pass_d  = tsc_pkg::PASS_MEAN;
            cnt_d   = '0;
            state_d = tsc_pkg::ST_SUM;
          end else begin
            state_d = tsc_pkg::ST_OUT;
          end
        end
      end
      tsc_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = tsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    in_ready_o     = (state_q == tsc_pkg::ST_IDLE);
    out_valid_o    = (state_q == tsc_pkg::ST_OUT);
    ctl_o.pass     = pass_q;
    ctl_o.idx      = cnt_q;
    ctl_o.accept   = accept;
    ctl_o.acc_add  = (state_q == tsc_pkg::ST_SUM);
    ctl_o.div_go   = (state_q == tsc_pkg::ST_DIV_GO);
    ctl_o.div_take = (state_q == tsc_pkg::ST_DIV_WAIT) && div_done_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsc_pkg::ST_IDLE;
      pass_q  <= tsc_pkg::PASS_RAW;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ hdl/touch_sensor_conditioner_core.sv @@
// Channel | Signals                                        | Direction
// in      | in_valid_i, in_ready_o, in_data_i (in_t)       | item in
// out     | out_valid_o, out_ready_i, out_data_o (out_t)   | result out
// cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
// One adder accumulates a ring one entry per cycle, and a two-stage constant divider
// turns the sum into a mean. A voltage sample takes two ring passes (raw ring, then mean
// ring), a capacitance sample one, and a decide or unused op none. The block takes one
// transaction at a time; the result is held on the output until taken, and the next
// transaction is accepted in the cycle after that.
// Reset clears all rings, slots, smoothed values and the touch state at once.
module touch_sensor_conditioner_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tsc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tsc_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tsc_pkg::CAP_W-1:0]     cfg_data_i
);

  tsc_pkg::ctl_t ctl;
  logic          div_done;
  logic signed [tsc_pkg::SUM_W-1:0] div_quot;
  logic signed [tsc_pkg::SUM_W-1:0] acc_q, addend;

  logic [tsc_pkg::VOLT_W-1:0]       raw_ring_q  [tsc_pkg::WINDOW];
  logic [tsc_pkg::VOLT_W-1:0]       mean_ring_q [tsc_pkg::WINDOW];
  logic signed [tsc_pkg::CAP_W-1:0] cap_ring_q  [tsc_pkg::WINDOW];
  logic [tsc_pkg::IDX_W-1:0]        volt_slot_q, cap_slot_q;
  logic [tsc_pkg::VOLT_W-1:0]       volt_value_q;
  logic signed [tsc_pkg::CAP_W-1:0] cap_value_q;
  logic                             touch_q;

  logic [tsc_pkg::TYPE_W-1:0]       switch_type_q;
  logic signed [tsc_pkg::CAP_W-1:0] th_high_q, th_low_q;

  logic [tsc_pkg::VOLT_W-1:0]       raw_sel, mean_sel;
  logic signed [tsc_pkg::CAP_W-1:0] cap_sel;
  logic                             is_volt, is_cap, is_decide;

  tsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .out_ready_i (out_ready_i),
    .div_done_i  (div_done),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  tsc_cdiv u_cdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (ctl.div_go),
    .sum_i  (acc_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign is_volt   = ctl.accept && (in_data_i.op == tsc_pkg::OP_VOLT);
  assign is_cap    = ctl.accept && (in_data_i.op == tsc_pkg::OP_CAP);
  assign is_decide = ctl.accept && (in_data_i.op == tsc_pkg::OP_DECIDE);

  // Configuration writes are always taken; an index past the list is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_type_q <= '0;
      th_high_q     <= tsc_pkg::TH_HIGH_RST;
      th_low_q      <= tsc_pkg::TH_LOW_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tsc_pkg::CFG_SWITCH_TYPE: switch_type_q <= cfg_data_i[tsc_pkg::TYPE_W-1:0];
        tsc_pkg::CFG_TH_HIGH:     th_high_q     <= $signed(cfg_data_i);
        tsc_pkg::CFG_TH_LOW:      th_low_q      <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Pick the ring entry that the adder takes this cycle, extended to the sum width.
  always_comb begin
    raw_sel  = raw_ring_q[ctl.idx];
    mean_sel = mean_ring_q[ctl.idx];
    cap_sel  = cap_ring_q[ctl.idx];
    case (ctl.pass)
      tsc_pkg::PASS_RAW:
        addend = $signed({{(tsc_pkg::SUM_W - tsc_pkg::VOLT_W){1'b0}}, raw_sel});
      tsc_pkg::PASS_MEAN:
        addend = $signed({{(tsc_pkg::SUM_W - tsc_pkg::VOLT_W){1'b0}}, mean_sel});
      tsc_pkg::PASS_CAP:
        addend = $signed({{(tsc_pkg::SUM_W - tsc_pkg::CAP_W){cap_sel[tsc_pkg::CAP_W-1]}},
                          cap_sel});
      default:
        addend = '0;
    endcase
  end

  // Shared accumulator, cleared at the start of each ring pass.
  always_ff @(posedge clk_i) begin
    if (ctl.accept || (ctl.div_take && ctl.pass == tsc_pkg::PASS_RAW)) begin
      acc_q <= '0;
    end else if (ctl.acc_add) begin
      acc_q <= acc_q + addend;
    end
  end

  // Rings, slots, smoothed values and the touch state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tsc_pkg::WINDOW; i++) begin
        raw_ring_q[i]  <= '0;
        mean_ring_q[i] <= '0;
        cap_ring_q[i]  <= '0;
      end
      volt_slot_q  <= '0;
      cap_slot_q   <= '0;
      volt_value_q <= '0;
      cap_value_q  <= '0;
      touch_q      <= 1'b0;
    end else begin
      if (is_volt) begin
        raw_ring_q[volt_slot_q] <= in_data_i.volt_sample;
      end
      if (is_cap) begin
        cap_ring_q[cap_slot_q] <= in_data_i.cap_sample;
      end
      if (is_decide) begin
        if (switch_type_q == '0) begin
          touch_q <= 1'b0;
        end else if (cap_value_q > th_high_q) begin
          touch_q <= 1'b1;
        end else if (cap_value_q < th_low_q) begin
          touch_q <= 1'b0;
        end
      end
      if (ctl.div_take) begin
        case (ctl.pass)
          tsc_pkg::PASS_RAW: begin
            mean_ring_q[volt_slot_q] <= div_quot[tsc_pkg::VOLT_W-1:0];
          end
          tsc_pkg::PASS_MEAN: begin
            volt_value_q <= div_quot[tsc_pkg::VOLT_W-1:0];
            volt_slot_q  <= (volt_slot_q == tsc_pkg::IDX_W'(tsc_pkg::WINDOW - 1)) ?
                            '0 : volt_slot_q + 1'b1;
          end
          tsc_pkg::PASS_CAP: begin
            cap_value_q <= div_quot[tsc_pkg::CAP_W-1:0];
            cap_slot_q  <= (cap_slot_q == tsc_pkg::IDX_W'(tsc_pkg::WINDOW - 1)) ?
                           '0 : cap_slot_q + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // The result stays steady while the sequencer holds it for the consumer.
  assign out_data_o.smoothed_volt = volt_value_q;
  assign out_data_o.smoothed_cap  = cap_value_q;
  assign out_data_o.touched       = touch_q;

endmodule

@@ tb/sv/touch_sensor_conditioner_core_test.sv @@
module touch_sensor_conditioner_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsc_pkg::*;

  localparam int CAP_MIN = -8388608;
  localparam int CAP_MAX = 8388607;
  localparam int VOLT_MAX = 1023;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 500;

  // Tracks the conditioner state and checks every result against it.
  class conditioner_tracker;
    logic [TYPE_W-1:0] switch_kind;
    int   th_high;
    int   th_low;
    int   raw_volts[WINDOW];
    int   mean_volts[WINDOW];
    int   caps[WINDOW];
    int   volt_pos;
    int   cap_pos;
    int   volt_avg;
    int   cap_avg;
    bit   touch;
    out_t pending_readings[$];
    int   mismatches;

    // Rings, slots and smoothed values start at zero as class members.
    function new();
      switch_kind = '0;
      th_high = TH_HIGH_RST;
      th_low = TH_LOW_RST;
    endfunction

    // Integer mean of one ring; division truncates toward zero.
    function int ring_mean(input int ring[WINDOW]);
      int sum;
      sum = 0;
      for (int i = 0; i < int'(WINDOW); i++) begin
        sum += ring[i];
      end
      return sum / int'(WINDOW);
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
      case (idx)
        CFG_SWITCH_TYPE: switch_kind = data[TYPE_W-1:0];
        CFG_TH_HIGH: th_high = int'($signed(data));
        CFG_TH_LOW: th_low = int'($signed(data));
        default: ;
      endcase
    endfunction

    // Advances the state for one accepted event and queues its reading.
    function void predict_item(in_t item);
      out_t reading;
      case (item.op)
        OP_VOLT: begin
          raw_volts[volt_pos] = int'(item.volt_sample);
          mean_volts[volt_pos] = ring_mean(raw_volts);
          volt_pos = (volt_pos + 1) % int'(WINDOW);
          volt_avg = ring_mean(mean_volts);
        end
        OP_CAP: begin
          caps[cap_pos] = int'($signed(item.cap_sample));
          cap_pos = (cap_pos + 1) % int'(WINDOW);
          cap_avg = ring_mean(caps);
        end
        OP_DECIDE: begin
          // Hysteresis: between the thresholds the touch state holds.
          if (switch_kind != '0) begin
            if (cap_avg > th_high) begin
              touch = 1'b1;
            end else if (cap_avg < th_low) begin
              touch = 1'b0;
            end
          end else begin
            touch = 1'b0;
          end
        end
        default: ;
      endcase
      reading.smoothed_volt = volt_avg[VOLT_W-1:0];
      reading.smoothed_cap = cap_avg[CAP_W-1:0];
      reading.touched = touch;
      pending_readings.push_back(reading);
    endfunction

    function void check_reading(out_t got);
      out_t want;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result with no transaction waiting: volt=%0d cap=%0d touched=%0b",
                   got.smoothed_volt, $signed(got.smoothed_cap), got.touched);
        end
        return;
      end
      want = pending_readings.pop_front();
      if (got.smoothed_volt !== want.smoothed_volt || got.smoothed_cap !== want.smoothed_cap ||
          got.touched !== want.touched) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: expected volt=%0d cap=%0d touched=%0b, got volt=%0d cap=%0d touched=%0b",
                   want.smoothed_volt, $signed(want.smoothed_cap), want.touched,
                   got.smoothed_volt, $signed(got.smoothed_cap), got.touched);
        end
      end
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  in_t                  in_data = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAP_W-1:0]     cfg_data = '0;
  logic                 in_ready;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_ready;

  conditioner_tracker tracker = new();
  int accepted_items = 0;

  touch_sensor_conditioner_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog for a hung handshake.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Every transaction on the three channels is observed here at the clock edge.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      tracker.check_reading(out_data);
    end
    if (cfg_valid && cfg_ready) begin
      tracker.apply_register(cfg_index, cfg_data);
    end
    if (in_valid && in_ready) begin
      tracker.predict_item(in_data);
      accepted_items++;
    end
  end

  // Result side: random ready pattern plus one long hold-off to back up the input.
  initial begin
    int  run;
    bit  level;
    bit  held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && accepted_items >= HOLD_AFTER) begin
        held = 1'b1;
        level = 1'b0;
        run = HOLD_CYCLES;
      end else begin
        level = ($urandom_range(0, 99) < 70);
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      end
      out_ready <= level;
      repeat (run) @(posedge clk);
    end
  end

  // Mostly short gaps, now and then a long one; zero when idling is off.
  function automatic int pick_gap(int idle_pct);
    if ($urandom_range(0, 99) >= idle_pct) begin
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 50);
    end
    return $urandom_range(1, 3);
  endfunction

  // A spread of zero asks for the full signed range with extra weight on the ends.
  function automatic int pick_cap(int mid, int spread);
    longint c;
    if (spread == 0) begin
      case ($urandom_range(0, 7))
        0: c = CAP_MIN;
        1: c = CAP_MAX;
        default: c = $signed(CAP_W'($urandom));
      endcase
    end else begin
      c = longint'(mid) + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
      if (c < CAP_MIN) begin
        c = CAP_MIN;
      end
      if (c > CAP_MAX) begin
        c = CAP_MAX;
      end
    end
    return int'(c);
  endfunction

  // Fields the event does not use still get random content.
  function automatic in_t make_item(op_e op, int volt, int cap);
    in_t item;
    item.op = op;
    item.volt_sample = (op == OP_VOLT) ? volt[VOLT_W-1:0] : VOLT_W'($urandom);
    item.cap_sample = (op == OP_CAP) ? cap[CAP_W-1:0] : CAP_W'($urandom);
    return item;
  endfunction

  // Offers one transaction and waits for it; valid stays up when no gap follows.
  task automatic send_item(in_t item, int gap_after);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (gap_after > 0) begin
      in_valid <= 1'b0;
      repeat (gap_after) @(posedge clk);
    end
  endtask

  task automatic send_repeated(op_e op, int value, int count);
    for (int i = 0; i < count; i++) begin
      send_item(make_item(op, value, value), pick_gap(30) + 1);
    end
  endtask

  // Register writes only go out once every pending reading has come back.
  task automatic write_reg(cfg_e idx, int value);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CAP_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int kind, int high, int low);
    write_reg(CFG_SWITCH_TYPE, kind);
    write_reg(CFG_TH_HIGH, high);
    write_reg(CFG_TH_LOW, low);
  endtask

  task automatic run_phase(int cap_mid, int cap_spread, int idle_pct);
    int   sel;
    int   volt;
    op_e  op;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        op = OP_VOLT;
      end else if (sel < 70) begin
        op = OP_CAP;
      end else if (sel < 95) begin
        op = OP_DECIDE;
      end else begin
        op = OP_NONE;
      end
      if ($urandom_range(0, 9) == 0) begin
        volt = $urandom_range(0, 1) ? VOLT_MAX : 0;
      end else begin
        volt = $urandom_range(0, VOLT_MAX);
      end
      send_item(make_item(op, volt, pick_cap(cap_mid, cap_spread)),
                (i == ITEMS_PER_PHASE - 1) ? 1 : pick_gap(idle_pct));
    end
  endtask

  initial begin
    int th_hi;
    int th_lo;
    int kind;
    wait (rst_n);
    @(posedge clk);

    // Directed part under reset settings: unused op, voltage extremes, maximum capacitance, decide with no switch.
    send_item(make_item(OP_NONE, 0, 0), 1);
    send_repeated(OP_VOLT, VOLT_MAX, 5);
    send_repeated(OP_VOLT, 0, 1);
    send_repeated(OP_CAP, CAP_MAX, 5);
    send_repeated(OP_DECIDE, 0, 1);

    // With a switch: set above high, hold between thresholds, clear below low.
    write_reg(CFG_SWITCH_TYPE, 255);
    send_repeated(OP_DECIDE, 0, 1);
    send_repeated(OP_CAP, 75, 5);
    send_repeated(OP_DECIDE, 0, 1);
    send_repeated(OP_CAP, CAP_MIN, 5);
    send_repeated(OP_DECIDE, 0, 1);

    // Nominal thresholds with samples around the hysteresis band.
    set_config(1, 100, 50);
    run_phase(75, 200, 0);

    // Widest band: no capacitance ever leaves it.
    set_config(255, CAP_MAX, CAP_MIN);
    write_reg(CFG_UNUSED, $urandom);
    run_phase(0, 0, 40);

    // No switch with random thresholds.
    set_config(0, $signed(CAP_W'($urandom)), $signed(CAP_W'($urandom)));
    run_phase(0, 0, 30);

    // Low threshold above the high one.
    set_config(170, CAP_MIN, CAP_MAX);
    run_phase(0, 0, 50);

    // Random settings, samples centered on the thresholds; the last phase uses full-range samples.
    for (int p = 0; p < 6; p++) begin
      kind = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 255);
      if (p == 5) begin
        th_hi = $signed(CAP_W'($urandom));
        th_lo = $signed(CAP_W'($urandom));
        set_config(kind, th_hi, th_lo);
        run_phase(0, 0, 0);
      end else begin
        th_hi = int'($urandom_range(0, 4000)) - 2000;
        th_lo = th_hi - int'($urandom_range(0, 500));
        set_config(kind, th_hi, th_lo);
        run_phase(th_hi, 300 + th_hi - th_lo, (p % 2 == 1) ? $urandom_range(20, 60) : 0);
      end
    end

    // Drain and let the block settle before the verdict.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ touch_sensor_conditioner_core.f @@
hdl/tsc_pkg.sv
hdl/tsc_cdiv.sv
hdl/tsc_ctrl.sv
hdl/touch_sensor_conditioner_core.sv
tb/sv/touch_sensor_conditioner_core_test.sv
